// File: design/mf3_pkg.sv
// Package for the 3x3 median filter: widths, reset values, register indexes
// and the result-set record that travels from the window pipeline to the output queue.
// No dependencies.
package mf3_pkg;

  localparam int PIX_W   = 8;
  localparam int COORD_W = 10;
  localparam int SIZE_W  = 11;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int MIN_SIZE       = 3;

  localparam logic [SIZE_W-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = 11'd480;

  // Register index, taken from paddr bit 2.
  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  // Depth of the result-set queue in front of the output port.
  localparam int QUEUE_DEPTH = 8;

  // Bit positions in the result mask, in emission order.
  localparam int RES_INNER     = 0;
  localparam int RES_ROW_END   = 1;
  localparam int RES_LAST_ROW  = 2;
  localparam int RES_FRAME_END = 3;
  localparam int RES_N         = 4;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [COORD_W-1:0] coord_t;

  // All results caused by one input pixel.
  typedef struct packed {
    logic [RES_N-1:0] mask;
    coord_t           row_a;   // r-1
    coord_t           col_a;   // c-1
    coord_t           wm1;     // width-1
    coord_t           hm1;     // height-1
    pix_t             med;     // median, already zero when not interior
  } mf3_set_t;

endpackage

// File: design/mf3_line_mem.sv
// Line store memory: one word per column holding the two previous rows.
// Synchronous read through an output register, one write port. Uses mf3_pkg.
module mf3_line_mem #(
  parameter int DEPTH = mf3_pkg::DEF_MAX_WIDTH
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [2*mf3_pkg::PIX_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [2*mf3_pkg::PIX_W-1:0] wr_data
);
  import mf3_pkg::*;

  logic [2*PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/mf3_median.sv
// Window and median pipeline: sorts each incoming column, keeps the two previous
// sorted columns and reduces the nine values to their median over two more stages. Uses mf3_pkg.
module mf3_median (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          col_valid,
  input  mf3_pkg::pix_t col_up,
  input  mf3_pkg::pix_t col_lo,
  input  mf3_pkg::pix_t col_cur,
  output mf3_pkg::pix_t med
);
  import mf3_pkg::*;

  typedef struct packed {
    pix_t hi;
    pix_t mid;
    pix_t lo_v;
  } col_t;

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic col_t sort3(pix_t a, pix_t b, pix_t c);
    col_t s;
    s.lo_v = min2(min2(a, b), c);
    s.hi   = max2(max2(a, b), c);
    s.mid  = med3(a, b, c);
    return s;
  endfunction

  col_t win_old_r, win_mid_r;   // columns c-2 and c-1
  col_t new_col;
  col_t cols_r [3];
  pix_t lo_max_r, mid_med_r, hi_min_r;

  assign new_col = sort3(col_up, col_lo, col_cur);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_old_r <= '0;
      win_mid_r <= '0;
    end else if (col_valid) begin
      win_old_r <= win_mid_r;
      win_mid_r <= new_col;
    end
  end

  always_ff @(posedge clk) begin
    cols_r[0] <= win_old_r;
    cols_r[1] <= win_mid_r;
    cols_r[2] <= new_col;
  end

  // With every column sorted, the median of nine is the median of the largest
  // low, the middle mid and the smallest high.
  always_ff @(posedge clk) begin
    lo_max_r  <= max2(max2(cols_r[0].lo_v, cols_r[1].lo_v), cols_r[2].lo_v);
    mid_med_r <= med3(cols_r[0].mid, cols_r[1].mid, cols_r[2].mid);
    hi_min_r  <= min2(min2(cols_r[0].hi, cols_r[1].hi), cols_r[2].hi);
  end

  assign med = med3(lo_max_r, mid_med_r, hi_min_r);

endmodule

// File: design/mf3_out_queue.sv
// Result-set queue and output serializer: stores result sets and sends their
// results one per cycle while out_stall is low, through a registered output. Uses mf3_pkg.
module mf3_out_queue (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    push,
  input  mf3_pkg::mf3_set_t                       push_set,
  output logic [$clog2(mf3_pkg::QUEUE_DEPTH+1)-1:0] count,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output mf3_pkg::coord_t                         out_row,
  output mf3_pkg::coord_t                         out_col,
  output mf3_pkg::pix_t                           out_pixel,
  output logic                                    out_frame_last
);
  import mf3_pkg::*;

  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int CNW = $clog2(QUEUE_DEPTH + 1);

  mf3_set_t         q_mem [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNW-1:0]   count_r, count_nxt;
  logic [RES_N-1:0] sent_r, pending, pick;
  mf3_set_t         head;
  logic             load, pop, last_of_set;
  logic             out_valid_r, out_last_r;
  coord_t           out_row_r, out_col_r, row_nxt, col_nxt;
  pix_t             out_pix_r, pix_nxt;
  logic             last_nxt;

  assign head        = q_mem[rd_ptr_r];
  assign pending     = head.mask & ~sent_r;
  assign pick        = pending & (~pending + RES_N'(1));
  assign last_of_set = (pending & ~pick) == '0;
  assign load        = (count_r != '0) && (!out_valid_r || !out_stall);
  assign pop         = load && last_of_set;

  always_comb begin
    row_nxt  = head.hm1;
    col_nxt  = head.wm1;
    pix_nxt  = '0;
    last_nxt = 1'b0;
    priority if (pending[RES_INNER]) begin
      row_nxt = head.row_a;
      col_nxt = head.col_a;
      pix_nxt = head.med;
    end else if (pending[RES_ROW_END]) begin
      row_nxt = head.row_a;
      col_nxt = head.wm1;
    end else if (pending[RES_LAST_ROW]) begin
      row_nxt = head.hm1;
      col_nxt = head.col_a;
    end else begin
      last_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_set;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNW'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - CNW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      sent_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (load) begin
        sent_r      <= last_of_set ? '0 : (sent_r | pick);
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_row_r  <= row_nxt;
      out_col_r  <= col_nxt;
      out_pix_r  <= pix_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign count          = count_r;
  assign out_valid      = out_valid_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_pixel      = out_pix_r;
  assign out_frame_last = out_last_r;

endmodule

// File: design/median_filter_3x3_top.sv
// A result passes the pipeline stages, then the result queue, then the output register.
// Throughput, out_stall low: one pixel per cycle while each pixel causes at most one result;
// the output port sends one result per cycle. The 8-entry result queue absorbs the two results
// of a last-column pixel, but in the last row pixels cause two results each, the queue fills
// and the input is stalled to half rate. Line memory: one read, one write per pixel and cycle.
// Reset (synchronous, rst_n low): size registers return to 640x480, counters, window and queue
// clear. The line memory is not cleared and has no clearing pass.
module median_filter_3x3_top
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mf3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Pixel input channel.
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mf3_pkg::PIX_W-1:0]   in_pixel,
  // Result channel.
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mf3_pkg::COORD_W-1:0] out_row,
  output logic [mf3_pkg::COORD_W-1:0] out_col,
  output logic [mf3_pkg::PIX_W-1:0]   out_pixel,
  output logic                        out_frame_last,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mf3_pkg::ADDR_W-1:0]  paddr,
  input  logic [mf3_pkg::DATA_W-1:0]  pwdata,
  output logic [mf3_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  // Column and row counter widths, and widths able to hold the sizes themselves.
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int CRW = $clog2(QUEUE_DEPTH + 4);

  // ---------------------------------------------------------------------------
  // Configuration registers. Register index is paddr bit 2, so every address
  // in the 3-bit space maps onto one of the two registers.
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0] cfg_width_r, cfg_height_r;
  logic              cfg_wr;
  logic              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= RESET_WIDTH;
      cfg_height_r <= RESET_HEIGHT;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_IDX_WIDTH:  cfg_width_r  <= pwdata[SIZE_W-1:0];
        REG_IDX_HEIGHT: cfg_height_r <= pwdata[SIZE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_IDX_WIDTH:  prdata = DATA_W'(cfg_width_r);
      REG_IDX_HEIGHT: prdata = DATA_W'(cfg_height_r);
    endcase
  end

  // Effective frame size, clamped to [3, MAX].
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (cfg_width_r < SIZE_W'(MIN_SIZE)) begin
      w_eff = WW'(MIN_SIZE);
    end else if (int'(cfg_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width_r);
    end
    if (cfg_height_r < SIZE_W'(MIN_SIZE)) begin
      h_eff = HW'(MIN_SIZE);
    end else if (int'(cfg_height_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg_height_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: position of the accepted pixel, result flags and memory read.
  // The counters first wrap in case the size shrank below them, then the
  // pixel's row and column are known and the next position is worked out.
  // ---------------------------------------------------------------------------
  logic          in_accept;
  logic [CW-1:0] col_r, col_nxt, cur_col;
  logic [RW-1:0] row_r, row_nxt, cur_row;
  logic [HW-1:0] row_inc, r_plus;
  logic [WW-1:0] c_plus;
  logic          pre_wrap, col_end, row_end;
  logic          row_nz, col_nz, interior;
  mf3_set_t      s0_set;

  assign in_accept = in_valid && !in_stall;

  always_comb begin
    pre_wrap = WW'(col_r) >= w_eff;
    cur_col  = pre_wrap ? '0 : col_r;
    row_inc  = HW'(row_r) + HW'(pre_wrap);
    cur_row  = (row_inc >= h_eff) ? '0 : RW'(row_inc);

    c_plus  = WW'(cur_col) + WW'(1);
    r_plus  = HW'(cur_row) + HW'(1);
    col_end = c_plus >= w_eff;          // pixel sits in the last column
    row_end = r_plus == h_eff;          // pixel sits in the last row

    if (col_end) begin
      col_nxt = '0;
      row_nxt = (r_plus >= h_eff) ? '0 : RW'(r_plus);
    end else begin
      col_nxt = CW'(c_plus);
      row_nxt = cur_row;
    end

    row_nz   = cur_row != '0;
    col_nz   = cur_col != '0;
    interior = (cur_row > RW'(1)) && (cur_col > CW'(1));

    s0_set.mask[RES_INNER]     = row_nz && col_nz;
    s0_set.mask[RES_ROW_END]   = row_nz && col_end;
    s0_set.mask[RES_LAST_ROW]  = row_end && col_nz;
    s0_set.mask[RES_FRAME_END] = row_end && col_end;
    s0_set.row_a = COORD_W'(cur_row - RW'(1));
    s0_set.col_a = COORD_W'(cur_col - CW'(1));
    s0_set.wm1   = COORD_W'(w_eff - WW'(1));
    s0_set.hm1   = COORD_W'(h_eff - HW'(1));
    s0_set.med   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line memory data returns. The column is shifted: the upper store
  // takes what was in the lower one, the lower store takes the new pixel.
  // Successive pixels always address different columns (width is at least 3),
  // so the write-back never meets a read of the same entry in flight.
  // ---------------------------------------------------------------------------
  logic                 s1_v_r, s2_v_r, s3_v_r;
  logic [CW-1:0]        s1_addr_r;
  pix_t                 s1_pix_r;
  mf3_set_t             s1_set_r, s2_set_r, s3_set_r;
  logic                 s1_int_r, s2_int_r, s3_int_r;
  logic [2*PIX_W-1:0]   rd_data;
  pix_t                 mem_up, mem_lo, med;

  assign mem_up = rd_data[2*PIX_W-1:PIX_W];
  assign mem_lo = rd_data[PIX_W-1:0];

  mf3_line_mem #(
    .DEPTH(MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (cur_col),
    .rd_data (rd_data),
    .wr_en   (s1_v_r),
    .wr_addr (s1_addr_r),
    .wr_data ({mem_lo, s1_pix_r})
  );

  // Stages 1 to 3 of the median: sort the column, reduce, final median.
  mf3_median u_median (
    .clk       (clk),
    .rst_n     (rst_n),
    .col_valid (s1_v_r),
    .col_up    (mem_up),
    .col_lo    (mem_lo),
    .col_cur   (s1_pix_r),
    .med       (med)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= cur_col;
    s1_pix_r  <= in_pixel;
    s1_set_r  <= s0_set;
    s1_int_r  <= interior;
    s2_set_r  <= s1_set_r;
    s2_int_r  <= s1_int_r;
    s3_set_r  <= s2_set_r;
    s3_int_r  <= s2_int_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: the finished result set enters the queue. Sets without any
  // result (first row, first column) are dropped here.
  // ---------------------------------------------------------------------------
  mf3_set_t       push_set;
  logic           push;
  logic [QCW-1:0] q_count;
  logic [CRW-1:0] used;

  always_comb begin
    push_set     = s3_set_r;
    push_set.med = s3_int_r ? med : '0;
  end

  assign push = s3_v_r && (s3_set_r.mask != '0);

  mf3_out_queue u_out_queue (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .push_set       (push_set),
    .count          (q_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_pixel      (out_pixel),
    .out_frame_last (out_frame_last)
  );

  // The pipeline never stops, so a pixel is only taken when the queue has a
  // free entry for it and for every pixel still between stages 1 and 3.
  assign used = CRW'(q_count) + CRW'(s1_v_r) + CRW'(s2_v_r) + CRW'(s3_v_r);
  assign in_stall = used >= CRW'(QUEUE_DEPTH);

endmodule

// File: design/mf3_checker.sv
// Port-level checker for the 3x3 median filter, bound to the top level.
// Depends on the top level's port names only.
module mf3_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [9:0] out_row,
  input logic [9:0] out_col,
  input logic [7:0] out_pixel,
  input logic       out_frame_last
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row) && $stable(out_col)
      && $stable(out_pixel) && $stable(out_frame_last))
    else $error("result changed while stalled");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Results on the top row, on the left column or at the frame end are border pixels and are zero.
  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_row == 10'd0 || out_col == 10'd0 || out_frame_last) |-> out_pixel == 8'd0)
    else $error("border result is not zero");

  // The end of a frame is never followed at once by another frame end.
  a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_frame_last |=> !(out_valid && out_frame_last))
    else $error("two frame ends in a row");

endmodule

bind median_filter_3x3_top mf3_checker u_mf3_checker (.*);

// File: bench/median_filter_3x3_checker.sv
`timescale 1ns / 100ps
// Checker for the 3x3 median filter: follows the size registers, works out the filtered
// pixels that every accepted pixel request causes and compares them with the result channel.
// Depends on mf3_pkg.
module median_filter_3x3_checker
  import mf3_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [PIX_W-1:0]   in_pixel,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [COORD_W-1:0] out_row,
  input  logic [COORD_W-1:0] out_col,
  input  logic [PIX_W-1:0]   out_pixel,
  input  logic               out_frame_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending_results
);

  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    coord_t row;
    coord_t col;
    pix_t   pixel;
    logic   last;
  } filtered_px_t;

  filtered_px_t      filtered_q[$];
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  pix_t              upper_line [DEF_MAX_WIDTH];
  pix_t              lower_line [DEF_MAX_WIDTH];
  pix_t              window_cols [6];
  int unsigned       row_pos;
  int unsigned       col_pos;

  function automatic int unsigned clamp_dim(logic [SIZE_W-1:0] v, int unsigned hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  // The median is the value with at most four smaller values and at least five values
  // that are not larger.
  function automatic pix_t median_of(pix_t [8:0] v);
    int below;
    int not_above;
    for (int i = 0; i < 9; i++) begin
      below = 0;
      not_above = 0;
      for (int j = 0; j < 9; j++) begin
        if (v[j] < v[i]) below++;
        if (v[j] <= v[i]) not_above++;
      end
      if (below <= 4 && not_above >= 5) return v[i];
    end
    return '0;
  endfunction

  function automatic void push_result(int unsigned r, int unsigned c, pix_t px, logic last);
    filtered_px_t item;
    item.row   = coord_t'(r);
    item.col   = coord_t'(c);
    item.pixel = px;
    item.last  = last;
    filtered_q.push_back(item);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (fail_count < MAX_REPORTS) $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // One pixel request: move the window and the line stores, then queue the results.
  function automatic void take_pixel(pix_t px);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    pix_t        up;
    pix_t        lo;
    pix_t        med;
    pix_t [8:0]  win;
    w = clamp_dim(width_reg, DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
    // A size that shrank under the counters takes effect here.
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;

    up = upper_line[c];
    lo = lower_line[c];
    upper_line[c] = lo;
    lower_line[c] = px;

    for (int i = 0; i < 6; i++) win[i] = window_cols[i];
    win[6] = up;
    win[7] = lo;
    win[8] = px;
    med = (r >= 2 && c >= 2) ? median_of(win) : '0;

    if (r >= 1 && c >= 1) push_result(r - 1, c - 1, med, 1'b0);
    if (r >= 1 && c == w - 1) push_result(r - 1, w - 1, '0, 1'b0);
    if (r == h - 1 && c >= 1) push_result(h - 1, c - 1, '0, 1'b0);
    if (r == h - 1 && c == w - 1) push_result(h - 1, w - 1, '0, 1'b1);

    for (int i = 0; i < 3; i++) window_cols[i] = window_cols[i + 3];
    window_cols[3] = up;
    window_cols[4] = lo;
    window_cols[5] = px;

    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  always @(posedge clk) begin : track
    filtered_px_t want;
    if (!rst_n) begin
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      for (int i = 0; i < 6; i++) window_cols[i] = '0;
      row_pos = 0;
      col_pos = 0;
      filtered_q.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_IDX_WIDTH:  width_reg = pwdata[SIZE_W-1:0];
          REG_IDX_HEIGHT: height_reg = pwdata[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_pixel(in_pixel);
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          if (fail_count < MAX_REPORTS) begin
            $error("result with nothing pending: row %0d col %0d", out_row, out_col);
          end
          fail_count++;
        end else begin
          want = filtered_q.pop_front();
          check_field("out_row", want.row, out_row);
          check_field("out_col", want.col, out_col);
          check_field("out_pixel", want.pixel, out_pixel);
          check_field("out_frame_last", want.last, out_frame_last);
        end
      end
    end
    pending_results <= filtered_q.size();
  end

endmodule

// File: bench/median_filter_3x3_top_test.sv
`timescale 1ns / 100ps
// Top of the median filter bench: clock, reset, pixel and register stimulus, a stalling
// result sink, a watchdog and the verdict. Depends on mf3_pkg, median_filter_3x3_top and
// median_filter_3x3_checker.
module median_filter_3x3_top_test;
  import mf3_pkg::*;

  // The slowest stretch without any handshake is the long receiver hold-off (LONG_HOLD)
  // plus a sender gap and the settling pause; STALL_LIMIT leaves a wide margin.
  localparam int STALL_LIMIT   = 3000;
  localparam int LONG_HOLD     = 200;
  // Results trail their pixel through the pipeline; pixels in the first row or column cause
  // none, so the block may still be busy after the last expected result.
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS  = 250;

  // Two 3x3 frames: alternating extremes with a median of 128, then distinct values.
  localparam pix_t DIRECTED_PIXELS [18] = '{
    8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80,
    8'd9, 8'd3, 8'd7, 8'd1, 8'd5, 8'd8, 8'd2, 8'd6, 8'd4
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [PIX_W-1:0]   in_pixel;
  logic               out_valid;
  logic               out_stall;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic [PIX_W-1:0]   out_pixel;
  logic               out_frame_last;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int fail_count;
  int pending_results;

  // Set by the stimulus to ask the result sink for one long hold-off.
  bit long_hold_request;
  // When clear, pixel requests go back to back.
  bit sender_gaps;

  // Frame position as seen by the stimulus, used to size well-formed frames.
  int unsigned frame_w;
  int unsigned frame_h;
  int unsigned frame_row;
  int unsigned frame_col;

  logic any_handshake;
  assign any_handshake = (in_valid && !in_stall) || (out_valid && !out_stall) ||
                         (psel && penable && pready);

  median_filter_3x3_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_pixel      (out_pixel),
    .out_frame_last (out_frame_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  median_filter_3x3_checker result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel        (in_pixel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_pixel       (out_pixel),
    .out_frame_last  (out_frame_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The sink stalls in spans: free stretches, short stalls and now and then a long one.
  // A long hold-off on request lets the sender fill the block until it stalls its input.
  initial begin : result_sink
    int pick;
    int span;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_request) begin
        long_hold_request = 1'b0;
        out_stall <= 1'b1;
        span = LONG_HOLD;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          out_stall <= 1'b0;
          span = $urandom_range(1, 30);
        end else if (pick < 93) begin
          out_stall <= 1'b1;
          span = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          span = $urandom_range(10, 40);
        end
      end
      repeat (span) @(posedge clk);
    end
  end

  // Ends the run when no handshake of any kind has happened for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (any_handshake) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Drops the pixel valid and waits until every expected result has come, then lets the
  // pipeline settle so that no pixel without a result is still in flight.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write: setup cycle, then access cycle until pready. The upper data bits
  // are random since only the low bits belong to the register.
  task automatic write_reg(logic idx, logic [SIZE_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {(DATA_W - SIZE_W)'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Sizes outside the legal range are clamped by the block; the stimulus tracks the
  // clamped size.
  task automatic write_size(logic [SIZE_W-1:0] raw_w, logic [SIZE_W-1:0] raw_h);
    wait_idle();
    write_reg(REG_IDX_WIDTH, raw_w);
    write_reg(REG_IDX_HEIGHT, raw_h);
    frame_w = (raw_w < MIN_SIZE) ? MIN_SIZE : (raw_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : raw_w;
    frame_h = (raw_h < MIN_SIZE) ? MIN_SIZE :
              (raw_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : raw_h;
  endtask

  // Offers one pixel request, after a random gap when gaps are on, and holds it until
  // it is accepted. The position follows the block's wrap rules.
  task automatic send_pixel(pix_t value);
    int pick;
    int gap;
    gap = 0;
    if (sender_gaps) begin
      pick = $urandom_range(0, 99);
      if (pick >= 95) gap = $urandom_range(8, 30);
      else if (pick >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);

    if (frame_col >= frame_w) begin
      frame_col = 0;
      frame_row++;
    end
    if (frame_row >= frame_h) frame_row = 0;
    frame_col++;
    if (frame_col >= frame_w) begin
      frame_col = 0;
      frame_row++;
      if (frame_row >= frame_h) frame_row = 0;
    end
  endtask

  // Random pixels, with some saturated and some clustered values so that the sort sees
  // ties and near ties.
  task automatic send_pixels(int unsigned count);
    pix_t px;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0:       px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        1:       px = pix_t'($urandom_range(120, 136));
        default: px = pix_t'($urandom());
      endcase
      send_pixel(px);
    end
  endtask

  initial begin : stimulus
    int unsigned       items;
    int unsigned       left;
    int unsigned       r;
    int unsigned       c;
    int unsigned       seg_len;
    logic [SIZE_W-1:0] raw_w;
    logic [SIZE_W-1:0] raw_h;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_pixel <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    sender_gaps = 1'b0;
    frame_w   = RESET_WIDTH;
    frame_h   = RESET_HEIGHT;
    frame_row = 0;
    frame_col = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Smallest frame at the minimum size, then again with both sizes written below the
    // legal range, which clamps back to 3x3. Each frame covers the border, the row end,
    // the last row and the frame end.
    write_size(11'd3, 11'd3);
    for (int i = 0; i < 9; i++) send_pixel(DIRECTED_PIXELS[i]);
    write_size(11'd0, 11'd2);
    for (int i = 9; i < 18; i++) send_pixel(DIRECTED_PIXELS[i]);

    // A frame as wide as the widest random frame. It fills every line store entry that
    // the random part can reach, so later size changes in mid-frame only ever read stored
    // pixels. The sink holds off for a long stretch meanwhile.
    write_size(11'd9, 11'd6);
    sender_gaps = 1'b1;
    long_hold_request = 1'b1;
    send_pixels(frame_w * frame_h);

    // Tall and narrow frame, pixel requests back to back.
    write_size(11'd3, 11'd12);
    sender_gaps = 1'b0;
    send_pixels(frame_w * frame_h);

    // Random part: mostly complete frames of small random sizes, some cut short so that
    // the next size lands in mid-frame and the counters have to wrap.
    items = 0;
    while (items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        raw_w = ($urandom_range(0, 9) == 0) ? SIZE_W'($urandom_range(0, 2))
                                            : SIZE_W'($urandom_range(3, 9));
        raw_h = ($urandom_range(0, 9) == 0) ? SIZE_W'($urandom_range(0, 2))
                                            : SIZE_W'($urandom_range(3, 6));
        write_size(raw_w, raw_h);
      end
      sender_gaps = ($urandom_range(0, 2) != 0);
      r = frame_row;
      c = frame_col;
      if (c >= frame_w) begin
        c = 0;
        r++;
      end
      if (r >= frame_h) r = 0;
      left = (frame_h - r) * frame_w - c;
      seg_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, left) : left;
      send_pixels(seg_len);
      items += seg_len;
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
